// ----- sv/kpsd_pkg.sv -----
// Package for the keypad scanner: shared types, constants and key table.
// No dependencies; used by every other file of the block.
`default_nettype none
package kpsd_pkg;

  localparam int unsigned ColW  = 3;
  localparam int unsigned RowW  = 3;
  localparam int unsigned KeyW  = 8;
  localparam int unsigned MsW   = 10;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [ColW-1:0] NoKeyCols = 3'h7;
  localparam logic [MsW-1:0]  MsMax     = 10'h3FF;
  localparam logic [RowW-1:0] RowFirst  = 3'd1;
  localparam logic [RowW-1:0] RowLast   = 3'd4;

  localparam logic [MsW-1:0] PressMsReset   = 10'd30;
  localparam logic [MsW-1:0] ReleaseMsReset = 10'd100;

  localparam logic [CfgIdxW-1:0] RegPressMs   = 1'd0;
  localparam logic [CfgIdxW-1:0] RegReleaseMs = 1'd1;

  typedef struct packed {
    logic [MsW-1:0] press_ms;
    logic [MsW-1:0] release_ms;
  } cfg_t;

  typedef struct packed {
    logic [KeyW-1:0] key_code;
    logic [RowW-1:0] row_select;
  } result_t;

  typedef logic [3:0][3:0][KeyW-1:0] key_map_t;

  localparam key_map_t KeyMap = '{
    '{8'h41, 8'h37, 8'h34, 8'h31},
    '{8'h30, 8'h38, 8'h35, 8'h32},
    '{8'h42, 8'h39, 8'h36, 8'h33},
    '{8'h43, 8'h44, 8'h45, 8'h46}
  };

  function automatic logic [KeyW-1:0] key_lookup(input logic [RowW-1:0] row,
                                                 input logic [ColW-1:0] cols);
    logic [1:0]      r;
    logic [KeyW-1:0] k;
    r = 2'(row - RowFirst);
    k = '0;
    if (row >= RowFirst && row <= RowLast) begin
      case (cols)
        3'd1: k = KeyMap[r][0];
        3'd2: k = KeyMap[r][1];
        3'd6: k = KeyMap[r][2];
        3'd4: k = KeyMap[r][3];
        default: k = '0;
      endcase
    end
    return k;
  endfunction

endpackage
`default_nettype wire

// ----- sv/kpsd_if.sv -----
// Stream interfaces for scan steps and results of the keypad scanner.
// Depends on kpsd_pkg.
`default_nettype none
interface kpsd_in_if;
  logic                     valid;
  logic                     ready;
  logic [kpsd_pkg::ColW-1:0] column_bits;
  logic                     ms_tick;
  modport source (output valid, output column_bits, output ms_tick, input ready);
  modport sink   (input valid, input column_bits, input ms_tick, output ready);
endinterface

interface kpsd_out_if;
  logic                     valid;
  logic                     ready;
  logic [kpsd_pkg::KeyW-1:0] key_code;
  logic [kpsd_pkg::RowW-1:0] row_select;
  modport source (output valid, output key_code, output row_select, input ready);
  modport sink   (input valid, input key_code, input row_select, output ready);
endinterface
`default_nettype wire

// ----- sv/kpsd_cfg_regs.sv -----
// Debounce time registers of the keypad scanner, written through a plain port.
// Depends on kpsd_pkg.
`default_nettype none
module kpsd_cfg_regs (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [kpsd_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [kpsd_pkg::MsW-1:0]     cfg_data,
  output kpsd_pkg::cfg_t                    cfg
);

  kpsd_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.press_ms   <= kpsd_pkg::PressMsReset;
      cfg_r.release_ms <= kpsd_pkg::ReleaseMsReset;
    end else if (cfg_we) begin
      case (cfg_index)
        kpsd_pkg::RegPressMs:   cfg_r.press_ms   <= cfg_data;
        kpsd_pkg::RegReleaseMs: cfg_r.release_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// ----- sv/kpsd_scan_fsm.sv -----
// Scan, debounce and lookup state machine; advances once per accepted step.
// Depends on kpsd_pkg.
`default_nettype none
module kpsd_scan_fsm (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      step,
  input  wire logic [kpsd_pkg::ColW-1:0] column_bits,
  input  wire logic                      ms_tick,
  input  wire kpsd_pkg::cfg_t            cfg,
  output kpsd_pkg::result_t              result
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_CAPTURE, ST_PRESS_WAIT, ST_LOOKUP,
    ST_REL_CHECK, ST_REL_WAIT, ST_REPORT
  } state_t;

  state_t                      state_r,    state_nxt;
  logic [kpsd_pkg::RowW-1:0]   row_r,      row_nxt;
  logic [kpsd_pkg::ColW-1:0]   captured_r, captured_nxt;
  logic [kpsd_pkg::KeyW-1:0]   held_r,     held_nxt;
  logic [kpsd_pkg::MsW-1:0]    elapsed_r,  elapsed_nxt;
  logic [kpsd_pkg::RowW-1:0]   row_eff;
  logic [kpsd_pkg::MsW-1:0]    elapsed_inc;
  logic                        no_key;

  always_comb begin
    row_eff = row_r;
    if (state_r == ST_IDLE &&
        (row_r < kpsd_pkg::RowFirst || row_r > kpsd_pkg::RowLast)) begin
      row_eff = kpsd_pkg::RowFirst;
    end
    no_key      = (column_bits == kpsd_pkg::NoKeyCols);
    elapsed_inc = (ms_tick && elapsed_r != kpsd_pkg::MsMax) ? elapsed_r + 1'b1 : elapsed_r;

    state_nxt    = state_r;
    row_nxt      = row_r;
    captured_nxt = captured_r;
    held_nxt     = held_r;
    elapsed_nxt  = elapsed_r;
    result.key_code   = '0;
    result.row_select = row_eff;

    case (state_r)
      ST_IDLE: begin
        held_nxt = '0;
        row_nxt  = row_eff;
        if (!no_key) begin
          state_nxt = ST_CAPTURE;
        end else begin
          row_nxt = row_eff + 1'b1;
        end
      end
      ST_CAPTURE: begin
        captured_nxt = column_bits;
        elapsed_nxt  = '0;
        state_nxt    = ST_PRESS_WAIT;
      end
      ST_PRESS_WAIT: begin
        elapsed_nxt = elapsed_inc;
        if (elapsed_inc >= cfg.press_ms) begin
          state_nxt = (column_bits == captured_r) ? ST_LOOKUP : ST_IDLE;
        end
      end
      ST_LOOKUP: begin
        held_nxt  = kpsd_pkg::key_lookup(row_r, captured_r);
        state_nxt = ST_REL_CHECK;
      end
      ST_REL_CHECK: begin
        if (!no_key) begin
          elapsed_nxt = '0;
          state_nxt   = ST_REL_WAIT;
        end else begin
          state_nxt = ST_REPORT;
        end
      end
      ST_REL_WAIT: begin
        if (!no_key) begin
          elapsed_nxt = '0;
        end else begin
          elapsed_nxt = elapsed_inc;
          if (elapsed_inc >= cfg.release_ms) begin
            state_nxt = ST_REPORT;
          end
        end
      end
      ST_REPORT: begin
        result.key_code = held_r;
        row_nxt         = kpsd_pkg::RowFirst;
        state_nxt       = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      row_r      <= kpsd_pkg::RowFirst;
      captured_r <= '0;
      held_r     <= '0;
      elapsed_r  <= '0;
    end else if (step) begin
      state_r    <= state_nxt;
      row_r      <= row_nxt;
      captured_r <= captured_nxt;
      held_r     <= held_nxt;
      elapsed_r  <= elapsed_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- sv/keypad_scan_debounce.sv -----
// Keypad scanner top level: config registers, scan state machine, result register.
// A result is valid in the cycle after its scan step transfers.
// Throughput: one scan step per cycle unless a held result is stalled by out_s.ready;
// the result register is the only buffer, refilled in the cycle it is taken.
// Reset (rst_n low, synchronous): idle, row 1, debounce times 30 ms and 100 ms.
`default_nettype none
module keypad_scan_debounce (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  kpsd_in_if.sink                           in_s,
  kpsd_out_if.source                        out_s,
  input  wire logic                         cfg_we,
  input  wire logic [kpsd_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [kpsd_pkg::MsW-1:0]     cfg_data
);

  kpsd_pkg::cfg_t    cfg;
  kpsd_pkg::result_t result;
  kpsd_pkg::result_t result_r;
  logic              out_valid_r;
  logic              in_xfer;

  assign in_s.ready = !out_valid_r || out_s.ready;
  assign in_xfer    = in_s.valid && in_s.ready;

  kpsd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  kpsd_scan_fsm u_fsm (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (in_xfer),
    .column_bits (in_s.column_bits),
    .ms_tick     (in_s.ms_tick),
    .cfg         (cfg),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_s.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      result_r <= result;
    end
  end

  assign out_s.valid      = out_valid_r;
  assign out_s.key_code   = result_r.key_code;
  assign out_s.row_select = result_r.row_select;

endmodule
`default_nettype wire

// ----- sim/keypad_scan_checker.sv -----
`timescale 1ns / 1ps
// Checker for the keypad scanner: tracks scan state and debounce registers on its own,
// predicts one result per scan step and compares each result transfer in order.
// Depends on kpsd_pkg and the stream interfaces in kpsd_if.
module keypad_scan_checker (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  kpsd_in_if                                steps,
  kpsd_out_if                               keys,
  input  wire logic                         cfg_we,
  input  wire logic [kpsd_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [kpsd_pkg::MsW-1:0]     cfg_data,
  output int unsigned                       pending_keys,
  output int unsigned                       error_count
);
  import kpsd_pkg::*;

  typedef enum logic [2:0] {
    StIdle,
    StCapture,
    StPressWait,
    StLookup,
    StRelCheck,
    StRelWait,
    StReport
  } scan_state_e;

  localparam logic [0:15][KeyW-1:0] KeyChars = "FEDC369B2580147A";

  scan_state_e     scan_st;
  logic [RowW-1:0] row_ctr;
  logic [ColW-1:0] captured;
  logic [KeyW-1:0] held_key;
  logic [MsW-1:0]  elapsed;
  cfg_t            debounce;
  result_t         expected_keys[$];

  function automatic logic [KeyW-1:0] decode_key(input logic [RowW-1:0] row,
                                                 input logic [ColW-1:0] cols);
    int col;
    case (cols)
      3'd1: col = 0;
      3'd2: col = 1;
      3'd6: col = 2;
      3'd4: col = 3;
      default: col = -1;
    endcase
    if (col < 0 || row < RowFirst || row > RowLast) return '0;
    return KeyChars[4'((int'(row) - 1) * 4 + col)];
  endfunction

  task automatic scan_step(input logic [ColW-1:0] cols, input logic tick,
                           output result_t res);
    res.key_code = '0;
    if (scan_st == StIdle && (row_ctr < RowFirst || row_ctr > RowLast)) row_ctr = RowFirst;
    res.row_select = row_ctr;
    case (scan_st)
      StIdle: begin
        held_key = '0;
        if (cols != NoKeyCols) scan_st = StCapture;
        else row_ctr = row_ctr + 1'b1;
      end
      StCapture: begin
        captured = cols;
        elapsed  = '0;
        scan_st  = StPressWait;
      end
      StPressWait: begin
        if (tick && elapsed != MsMax) elapsed = elapsed + 1'b1;
        if (elapsed >= debounce.press_ms) scan_st = (cols == captured) ? StLookup : StIdle;
      end
      StLookup: begin
        held_key = decode_key(row_ctr, captured);
        scan_st  = StRelCheck;
      end
      StRelCheck: begin
        if (cols != NoKeyCols) begin
          elapsed = '0;
          scan_st = StRelWait;
        end else begin
          scan_st = StReport;
        end
      end
      StRelWait: begin
        // restart the wait while any key is still down
        if (cols != NoKeyCols) begin
          elapsed = '0;
        end else begin
          if (tick && elapsed != MsMax) elapsed = elapsed + 1'b1;
          if (elapsed >= debounce.release_ms) scan_st = StReport;
        end
      end
      StReport: begin
        res.key_code = held_key;
        row_ctr      = RowFirst;
        scan_st      = StIdle;
      end
      default: scan_st = StIdle;
    endcase
  endtask

  always @(posedge clk) begin : track_p
    result_t got;
    result_t want;
    if (!rst_n) begin
      scan_st             = StIdle;
      row_ctr             = RowFirst;
      captured            = '0;
      held_key            = '0;
      elapsed             = '0;
      debounce.press_ms   = PressMsReset;
      debounce.release_ms = ReleaseMsReset;
      expected_keys.delete();
      error_count         = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == RegPressMs) debounce.press_ms = cfg_data;
        else if (cfg_index == RegReleaseMs) debounce.release_ms = cfg_data;
      end
      // compare before queueing, so a result never meets the step of the same edge
      if (keys.valid && keys.ready) begin
        got.key_code   = keys.key_code;
        got.row_select = keys.row_select;
        if (expected_keys.size() == 0) begin
          $error("unexpected result transfer: key_code %02h row_select %0d",
                 got.key_code, got.row_select);
          error_count++;
        end else begin
          want = expected_keys.pop_front();
          if (got.key_code !== want.key_code) begin
            $error("key_code: expected %02h, actual %02h", want.key_code, got.key_code);
            error_count++;
          end
          if (got.row_select !== want.row_select) begin
            $error("row_select: expected %0d, actual %0d", want.row_select, got.row_select);
            error_count++;
          end
        end
      end
      if (steps.valid && steps.ready) begin
        scan_step(steps.column_bits, steps.ms_tick, want);
        expected_keys.push_back(want);
      end
    end
    pending_keys = expected_keys.size();
  end

endmodule

// ----- sim/keypad_scan_debounce_test.sv -----
`timescale 1ns / 1ps
// Testbench top for keypad_scan_debounce: clock, reset, key press sequences and noise,
// debounce register writes and result back-pressure. Checking is in keypad_scan_checker.
// Depends on kpsd_pkg, kpsd_if, keypad_scan_checker and the block's RTL.
module keypad_scan_debounce_test;
  import kpsd_pkg::*;

  localparam int unsigned RandomSteps = 600;
  localparam int unsigned PhaseSteps  = 180;
  localparam int unsigned LongHoldOff = 300;
  localparam logic [0:3][ColW-1:0] ListedCols = {3'd1, 3'd2, 3'd4, 3'd6};

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [MsW-1:0]     cfg_data;
  int unsigned        pending_keys;
  int unsigned        error_count;
  int unsigned        steps_sent;
  int unsigned        burst_left;
  bit                 hold_off_req = 1'b0;
  logic [MsW-1:0]     press_ms;
  logic [MsW-1:0]     release_ms;

  kpsd_in_if  step_ch ();
  kpsd_out_if key_ch ();

  keypad_scan_debounce uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_s      (step_ch),
    .out_s     (key_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  keypad_scan_checker key_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .steps        (step_ch),
    .keys         (key_ch),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pending_keys (pending_keys),
    .error_count  (error_count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // result side: short and long stalls, open stretches, one long hold-off on request
  initial begin : receiver_p
    int unsigned stall_left;
    int unsigned open_left;
    int unsigned pick;
    logic        rdy;
    stall_left   = 0;
    open_left    = 0;
    key_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = LongHoldOff;
        open_left    = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else if (open_left > 0) begin
        open_left--;
        rdy = 1'b1;
      end else begin
        pick = $urandom_range(0, 99);
        rdy  = 1'b1;
        if (pick < 4) begin
          stall_left = $urandom_range(10, 40);
          rdy        = 1'b0;
        end else if (pick < 10) begin
          open_left = $urandom_range(20, 80);
        end else if (pick < 30) begin
          stall_left = $urandom_range(0, 2);
          rdy        = 1'b0;
        end
      end
      key_ch.ready <= rdy;
    end
  end

  function automatic logic roll_tick(input int unsigned pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic logic [ColW-1:0] pick_pattern();
    logic [ColW-1:0] p;
    if ($urandom_range(0, 99) < 80) return ListedCols[2'($urandom_range(0, 3))];
    do p = ColW'($urandom_range(0, 6)); while (p == 3'd1 || p == 3'd2 || p == 3'd4 || p == 3'd6);
    return p;
  endfunction

  task automatic send_step(input logic [ColW-1:0] cols, input logic tick);
    int unsigned gap;
    int unsigned pick;
    gap = 0;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 2) burst_left = $urandom_range(20, 80);
      else if (pick < 5) gap = $urandom_range(10, 40);
      else if (pick < 30) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      @(negedge clk);
      step_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    step_ch.valid       <= 1'b1;
    step_ch.column_bits <= cols;
    step_ch.ms_tick     <= tick;
    @(posedge clk);
    while (!step_ch.ready) @(posedge clk);
    steps_sent++;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [MsW-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == RegPressMs) press_ms = value;
    else release_ms = value;
  endtask

  task automatic drain();
    @(negedge clk);
    step_ch.valid <= 1'b0;
    while (pending_keys != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic set_debounce(input logic [MsW-1:0] press, input logic [MsW-1:0] rel);
    drain();
    write_reg(RegPressMs, press);
    write_reg(RegReleaseMs, rel);
  endtask

  // one key press: idle scan, hold, release; a broken one lets go early or slips
  task automatic key_press(input logic [ColW-1:0] pattern, input int unsigned tick_pct,
                           input bit clean, input int unsigned bounce_pct);
    int unsigned ticks;
    int unsigned need;
    logic        t;
    repeat ($urandom_range(0, 6)) send_step(NoKeyCols, roll_tick(tick_pct));
    send_step(pattern, roll_tick(tick_pct));
    send_step(pattern, roll_tick(tick_pct));
    need  = clean ? press_ms + 1 : $urandom_range(0, press_ms + 1);
    ticks = 0;
    while (ticks < need) begin
      t = roll_tick(tick_pct);
      send_step(pattern, t);
      if (t) ticks++;
    end
    repeat ($urandom_range(0, 2)) send_step(pattern, roll_tick(tick_pct));
    if (!clean) repeat ($urandom_range(1, 3)) send_step(ColW'($urandom_range(0, 7)), roll_tick(50));
    need  = release_ms + 1;
    ticks = 0;
    while (ticks < need) begin
      if ($urandom_range(0, 99) < bounce_pct) begin
        send_step(ColW'($urandom_range(0, 6)), roll_tick(tick_pct));
        ticks = 0;
      end else begin
        t = roll_tick(tick_pct);
        send_step(NoKeyCols, t);
        if (t) ticks++;
      end
    end
    repeat (2) send_step(NoKeyCols, roll_tick(tick_pct));
  endtask

  initial begin : stimulus_p
    int unsigned      random_end;
    int unsigned      phase_mark;
    int unsigned      kind;
    logic [ColW-1:0]  p;
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = RegPressMs;
    cfg_data            = '0;
    step_ch.valid       = 1'b0;
    step_ch.column_bits = NoKeyCols;
    step_ch.ms_tick     = 1'b0;
    press_ms            = PressMsReset;
    release_ms          = ReleaseMsReset;
    steps_sent          = 0;
    burst_left          = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // walk all rows and wrap, then start a capture of an unlisted pattern
    for (int i = 0; i < 5; i++) send_step(NoKeyCols, i[0]);
    send_step(3'd3, 1'b1);
    send_step(3'd3, 1'b0);
    key_press(3'd4, 90, 1'b1, 0);

    // zero debounce: waits end at once; listed, unlisted and still-held keys
    set_debounce('0, '0);
    foreach (ListedCols[i]) begin
      if (i == 0 || i == 3) begin
        p = (i == 0) ? 3'd1 : 3'd0;
        send_step(p, 1'b0);
        send_step(p, 1'b1);
        send_step(p, 1'b1);
        send_step(p, 1'b0);
        send_step(NoKeyCols, 1'b0);
        send_step(NoKeyCols, 1'b1);
      end
    end
    repeat (5) send_step(3'd2, 1'b1);
    send_step(NoKeyCols, 1'b0);
    send_step(NoKeyCols, 1'b0);

    set_debounce(10'd1, 10'd1);
    hold_off_req = 1'b1;
    random_end   = steps_sent + RandomSteps;
    phase_mark   = steps_sent;
    while (steps_sent < random_end) begin
      if (steps_sent - phase_mark >= PhaseSteps) begin
        if ($urandom_range(0, 4) == 0) begin
          set_debounce(MsW'($urandom_range(0, 40)), MsW'($urandom_range(0, 40)));
        end else begin
          set_debounce(MsW'($urandom_range(0, 12)), MsW'($urandom_range(0, 12)));
        end
        phase_mark = steps_sent;
      end
      kind = $urandom_range(0, 9);
      if (kind < 7) key_press(pick_pattern(), 75, 1'b1, 3);
      else if (kind < 9) key_press(pick_pattern(), 60, 1'b0, 10);
      else repeat ($urandom_range(1, 12)) begin
        send_step(ColW'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
      end
    end

    // long debounce times, one per register
    set_debounce(10'd520, 10'd1);
    key_press(pick_pattern(), 100, 1'b1, 0);
    set_debounce(10'd1, 10'd260);
    key_press(pick_pattern(), 100, 1'b1, 0);

    drain();
    repeat (5) @(posedge clk);
    if (error_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
